### rtl/skt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table package
// Field widths, operation and status codes, and the result record that the
// sequencer hands to the output stage.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int RESULT_W = INDEX_W + STATUS_W + COUNT_W;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FIND   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BELOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABOVE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
    } skt_result_t;

endpackage

### rtl/skt_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table storage
// Synchronous key memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module skt_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/skt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table sequencer
// Runs the binary search over the key memory, the upward shift for an insert
// and the status decision, and keeps the key count.
// ----------------------------------------------------------------------------
module skt_ctrl
    import skt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int KW    = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_func,
    input  logic [KW-1:0]            in_key,
    output logic                     rd_en,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [KW-1:0]            rd_data,
    output logic                     wr_en,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output logic [KW-1:0]            wr_data,
    output logic                     res_valid,
    input  logic                     res_ready,
    output skt_result_t              res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROBE  = 3'd1;
    localparam logic [2:0] S_SH_RD  = 3'd2;
    localparam logic [2:0] S_SH_WR  = 3'd3;
    localparam logic [2:0] S_INS_WR = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [KW-1:0] SIGN_BIT = {1'b1, {(KW-1){1'b0}}};

    logic [2:0]    state_reg, state_next;
    logic          func_reg, func_next;
    logic [KW-1:0] key_reg, key_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic          eq_reg, eq_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] count_reg, count_next;
    skt_result_t   res_reg, res_next;

    logic          le;
    logic [CW-1:0] lo_p, hi_p, last_idx, ptr_dec;
    logic          eq_p;

    // Midpoint of the open range [lo, hi); always below the key count.
    function automatic logic [AW-1:0] midpoint(input logic [CW-1:0] lo,
                                               input logic [CW-1:0] hi);
        logic [CW-1:0] s;
        s = lo + ((hi - lo) >> 1);
        return s[AW-1:0];
    endfunction

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        key_next   = key_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        eq_next    = eq_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = mid_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(lo_reg);
        wr_data    = key_reg;

        // One probe per cycle: the memory output holds the key at mid_reg.
        le       = (rd_data <= key_reg);
        last_idx = count_reg - CW'(1);
        lo_p     = le ? (CW'(mid_reg) + CW'(1)) : lo_reg;
        hi_p     = le ? hi_reg : CW'(mid_reg);
        eq_p     = (le && (CW'(mid_reg) == last_idx)) ? (rd_data == key_reg) : eq_reg;
        ptr_dec  = ptr_reg - CW'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = in_func;
                    // Inverting the sign bit makes unsigned order match signed order.
                    key_next  = in_key ^ SIGN_BIT;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    eq_next   = 1'b0;
                    ptr_next  = count_reg;
                    if (in_func == FUNC_FIND && count_reg == '0)
                    begin
                        res_next   = '{count: COUNT_W'(count_reg), status: ST_EMPTY,
                                       index: '0};
                        state_next = S_DONE;
                    end
                    else if (in_func == FUNC_INSERT && count_reg == CW'(DEPTH))
                    begin
                        res_next   = '{count: COUNT_W'(count_reg), status: ST_FULL,
                                       index: '0};
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = midpoint('0, count_reg);
                        mid_next   = midpoint('0, count_reg);
                        state_next = S_PROBE;
                    end
                end
            end

            S_PROBE:
            begin
                lo_next = lo_p;
                hi_next = hi_p;
                eq_next = eq_p;
                if (lo_p < hi_p)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = midpoint(lo_p, hi_p);
                    mid_next = midpoint(lo_p, hi_p);
                end
                else if (func_reg == FUNC_INSERT)
                begin
                    // lo_p is the insert position; move larger keys up first.
                    state_next = (ptr_reg == lo_p) ? S_INS_WR : S_SH_RD;
                end
                else
                begin
                    if (lo_p == '0)
                    begin
                        res_next = '{count: COUNT_W'(count_reg), status: ST_BELOW,
                                     index: '0};
                    end
                    else if (lo_p == count_reg && !eq_p)
                    begin
                        res_next = '{count: COUNT_W'(count_reg), status: ST_ABOVE,
                                     index: '0};
                    end
                    else
                    begin
                        res_next = '{count: COUNT_W'(count_reg), status: ST_OK,
                                     index: INDEX_W'(lo_p - CW'(1))};
                    end
                    state_next = S_DONE;
                end
            end

            S_SH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = AW'(ptr_dec);
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(ptr_reg);
                wr_data    = rd_data;
                ptr_next   = ptr_dec;
                state_next = (ptr_dec > lo_reg) ? S_SH_RD : S_INS_WR;
            end

            S_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(lo_reg);
                wr_data    = key_reg;
                count_next = count_reg + CW'(1);
                res_next   = '{count: COUNT_W'(count_reg + CW'(1)), status: ST_OK,
                               index: INDEX_W'(lo_reg)};
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        key_reg  <= key_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        eq_reg   <= eq_next;
        ptr_reg  <= ptr_next;
        res_reg  <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

### rtl/sorted_key_table_floor_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table with floor search
// Keeps signed keys in ascending order and answers floor-index queries.
// ----------------------------------------------------------------------------
// The block stores up to TABLE_DEPTH signed keys of KEY_WIDTH bits (Q16.16 at
// the default width) in ascending order in one synchronous memory. An insert
// (func 0) places the key after all stored keys that are less than or equal to
// it and returns that position; a find (func 1) returns the highest index whose
// key is less than or equal to the search key, or a status of below range,
// above range or empty table with index 0. An insert into a full table is
// dropped and reports table full. Every transfer yields exactly one result.
// Items are handled one at a time. A find starts the first read when taken,
// runs its binary-search probes (ceil(log2(count+1)), at most seven for a
// 64-entry table) and hands over the result; the probe loop is bound by the
// registered read of the key memory. An insert searches the same way, moves
// each stored key that must go up one place with a read and a write step,
// and ends with the write of the new key. A finished result waits in an
// output register, so the next input transfer is taken while it is pending.
// No clearing pass follows reset; only the key count and state are reset.
// ----------------------------------------------------------------------------
module sorted_key_table_floor_search_top
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0 up: func (1), key (KEY_WIDTH), zero fill to bytes.
    input  logic [((KEY_WIDTH + 8) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Fields from bit 0 up: index (6), status (3), count (7).
    output logic [RESULT_W-1:0]                    m_axis_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                 rd_en, wr_en;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [KEY_WIDTH-1:0] rd_data, wr_data;
    logic                 res_valid, res_ready;
    skt_result_t          res;

    logic                 out_valid_reg, out_valid_next;
    skt_result_t          out_data_reg;

    skt_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (KEY_WIDTH)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    skt_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .KW    (KEY_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tdata[0]),
        .in_key    (s_axis_tdata[KEY_WIDTH:1]),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register takes a new result when it is empty or being drained.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### verif/sorted_key_table_floor_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table checker
// Watches both stream channels, keeps its own copy of the sorted key table,
// and compares each result transfer with the predicted index, status and count.
// ----------------------------------------------------------------------------
module sorted_key_table_floor_search_checker
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    input  logic                                   s_axis_tready,
    // Fields from bit 0 up: func (1), key (KEY_WIDTH), zero fill to bytes.
    input  logic [((KEY_WIDTH + 8) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Fields from bit 0 up: index (6), status (3), count (7).
    input  logic [RESULT_W-1:0]                    m_axis_tdata,
    output int                                     mismatch_count,
    output int                                     pending,
    output int                                     results_done,
    output int                                     peak_fill,
    output logic [4:0]                             statuses_seen
);

    logic signed [KEY_WIDTH-1:0] sorted_keys [TABLE_DEPTH];
    int                          key_total = 0;
    int                          items_taken = 0;
    skt_result_t                 expected_results [$];

    initial
    begin
        mismatch_count = 0;
        results_done   = 0;
        peak_fill      = 0;
        statuses_seen  = '0;
    end

    assign pending = items_taken - results_done;

    // Applies one operation to the shadow table and returns the result it
    // must produce. The table is kept sorted, so the number of keys at or
    // below the operand is one past the highest index holding such a key.
    function automatic skt_result_t predict_transfer(
        input logic                        func,
        input logic signed [KEY_WIDTH-1:0] key
    );
        skt_result_t res;
        int          at_or_below;
        at_or_below = 0;
        res         = '0;
        for (int i = 0; i < key_total; i++)
        begin
            if (sorted_keys[i] <= key)
                at_or_below = i + 1;
        end
        if (func == FUNC_INSERT)
        begin
            if (key_total >= TABLE_DEPTH)
                res.status = ST_FULL;
            else
            begin
                for (int i = key_total; i > at_or_below; i--)
                    sorted_keys[i] = sorted_keys[i - 1];
                sorted_keys[at_or_below] = key;
                key_total++;
                res.status = ST_OK;
                res.index  = at_or_below[INDEX_W-1:0];
            end
        end
        else
        begin
            if (key_total == 0)
                res.status = ST_EMPTY;
            else if (key < sorted_keys[0])
                res.status = ST_BELOW;
            else if (key > sorted_keys[key_total - 1])
                res.status = ST_ABOVE;
            else
            begin
                res.status = ST_OK;
                res.index  = INDEX_W'(at_or_below - 1);
            end
        end
        res.count = key_total[COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        skt_result_t want;
        skt_result_t got;
        int          errs;
        errs = 0;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = predict_transfer(s_axis_tdata[0], s_axis_tdata[KEY_WIDTH:1]);
                expected_results = {expected_results, want};
                statuses_seen[want.status] <= 1'b1;
                if (key_total > peak_fill)
                    peak_fill <= key_total;
                items_taken <= items_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_results.size() == 0)
                begin
                    errs++;
                    $display("%0t: result with none expected: index %0d status %0d count %0d",
                             $time, got.index, got.status, got.count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.index != want.index)
                    begin
                        errs++;
                        $display("%0t: index expected %0d, actual %0d",
                                 $time, want.index, got.index);
                    end
                    if (got.status != want.status)
                    begin
                        errs++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.count != want.count)
                    begin
                        errs++;
                        $display("%0t: count expected %0d, actual %0d",
                                 $time, want.count, got.count);
                    end
                end
                results_done <= results_done + 1;
            end
            if (errs != 0)
                mismatch_count <= mismatch_count + errs;
        end
    end

endmodule

### verif/sorted_key_table_floor_search_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Drives inserts and floor searches with random idling on both channels and
// leaves all checking to the checker beside the block.
// ----------------------------------------------------------------------------
// The run starts with a short hand-picked sequence: a search in the empty
// table, searches below, above and exactly at the ends of the stored range,
// duplicate keys at zero and at both extremes of the signed key range. The
// random part then grows the table slowly with mostly searches aimed at stored
// keys, their neighbors and the extremes, fills it quickly until inserts are
// refused, and keeps searching the full table. On the way the receiver holds
// off for two long stretches so the block backs up into its input, and the
// sender twice stops until every result has come back.
// ----------------------------------------------------------------------------
module sorted_key_table_floor_search_top_tb;
    import skt_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int KEY_WIDTH    = 32;
    localparam int DATA_W       = ((KEY_WIDTH + 8) / 8) * 8;
    localparam int RANDOM_ITEMS = 1730;
    localparam int LONG_HOLD    = 400;
    // An insert into a nearly full table moves every key once with a read and a
    // write step each, so this covers the slowest item with room to spare.
    localparam int TAIL_CYCLES  = 4 * TABLE_DEPTH;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // Fields from bit 0 up: func (1), key (KEY_WIDTH), zero fill to bytes.
    logic [DATA_W-1:0]   s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // Fields from bit 0 up: index (6), status (3), count (7).
    logic [RESULT_W-1:0] m_axis_tdata;

    int                  mismatch_count;
    int                  pending;
    int                  results_done;
    int                  peak_fill;
    logic [4:0]          statuses_seen;

    // Keys already offered for insertion, so that searches can hit them.
    logic [KEY_WIDTH-1:0] placed_keys [$];
    int                   inserts_sent = 0;
    int                   finds_sent = 0;
    int                   calm_items = 0;

    always #5 clk = ~clk;

    sorted_key_table_floor_search_top #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sorted_key_table_floor_search_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .results_done   (results_done),
        .peak_fill      (peak_fill),
        .statuses_seen  (statuses_seen)
    );

    // Idle length for either side: mostly none or a few cycles, now and then
    // a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_WIDTH-1:0] extreme_key();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Insert keys mix the whole range with a narrow cluster around zero and
    // repeats of earlier keys, so that duplicates are common.
    function automatic logic [KEY_WIDTH-1:0] insert_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return $urandom;
        else if (roll < 65)
            return $urandom_range(0, 15) - 8;
        else if (roll < 80 && placed_keys.size() != 0)
            return placed_keys[$urandom_range(0, placed_keys.size() - 1)];
        else if (roll < 90)
            return extreme_key();
        return {16'($urandom_range(0, 16'hFFFF)), 16'h0000};
    endfunction

    // Search keys mostly land on a stored key or right next to one, which is
    // where the floor decision and the duplicate rule matter.
    function automatic logic [KEY_WIDTH-1:0] find_key();
        int                   roll;
        logic [KEY_WIDTH-1:0] hit;
        roll = $urandom_range(0, 99);
        if (placed_keys.size() != 0)
            hit = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
        else
            hit = $urandom;
        if (roll < 35)
            return hit;
        else if (roll < 55)
            return $urandom_range(0, 1) ? hit + 1 : hit - 1;
        else if (roll < 80)
            return $urandom;
        else if (roll < 90)
            return extreme_key();
        return $urandom_range(0, 15) - 8;
    endfunction

    // Offers one item and returns at the edge where it is accepted. The valid
    // line only drops when a gap is wanted, so back-to-back transfers keep it
    // high.
    task automatic send_transfer(input logic func, input logic [KEY_WIDTH-1:0] key);
        int gap;
        if (calm_items > 0)
        begin
            gap = 0;
            calm_items--;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 99) < 3)
                calm_items = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(DATA_W - KEY_WIDTH - 1){1'b0}}, key, func};
        do @(posedge clk); while (!s_axis_tready);
        if (func == FUNC_INSERT)
        begin
            inserts_sent++;
            placed_keys = {placed_keys, key};
        end
        else
            finds_sent++;
    endtask

    // Stops offering until every result so far has been taken.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Sender side.
    initial
    begin
        logic                 op;
        logic [KEY_WIDTH-1:0] k;
        int                   insert_pct;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, then a single zero key searched from both sides.
        send_transfer(FUNC_FIND,   32'h0000_0000);
        send_transfer(FUNC_INSERT, 32'h0000_0000);
        send_transfer(FUNC_FIND,   32'hFFFF_FFFF);
        send_transfer(FUNC_FIND,   32'h0000_0001);
        send_transfer(FUNC_FIND,   32'h0000_0000);
        // A duplicate goes after its equal and a search returns the later one.
        send_transfer(FUNC_INSERT, 32'h0000_0000);
        send_transfer(FUNC_FIND,   32'h0000_0000);
        // Both ends of the signed range, stored and searched exactly.
        send_transfer(FUNC_INSERT, 32'h7FFF_FFFF);
        send_transfer(FUNC_INSERT, 32'h8000_0000);
        send_transfer(FUNC_FIND,   32'h8000_0000);
        send_transfer(FUNC_FIND,   32'h7FFF_FFFF);
        send_transfer(FUNC_FIND,   32'hFFFF_FFFF);
        send_transfer(FUNC_INSERT, 32'h0001_0000);
        send_transfer(FUNC_FIND,   32'h0000_FFFF);
        send_transfer(FUNC_INSERT, 32'h8000_0000);
        send_transfer(FUNC_FIND,   32'h8000_0000);
        send_transfer(FUNC_INSERT, 32'h7FFF_FFFF);
        send_transfer(FUNC_FIND,   32'h7FFF_FFFF);
        send_transfer(FUNC_INSERT, 32'hFFFF_0000);
        send_transfer(FUNC_FIND,   32'h5555_5555);
        send_transfer(FUNC_FIND,   32'hAAAA_AAAA);

        // Slow growth with mostly searches, then a burst of inserts that runs
        // the table full, then searches against the full table.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 600 || n == 1350)
                wait_for_results();
            if (n < 1100)
                insert_pct = 4;
            else if (n < 1200)
                insert_pct = 60;
            else
                insert_pct = 10;
            op = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_FIND;
            k  = (op == FUNC_INSERT) ? insert_key() : find_key();
            send_transfer(op, k);
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d inserts and %0d floor searches; the table peaked at %0d keys.",
                 inserts_sent, finds_sent, peak_fill);
        $display("Statuses produced (empty, full, above, below, ok from the left): %b",
                 statuses_seen);
        if (mismatch_count == 0)
            $display("sorted_key_table_floor_search_top: match");
        else
            $display("sorted_key_table_floor_search_top: mismatch");
        $finish;
    end

    // Receiver side: open and stalled stretches of random length, with two
    // long hold-offs that let the block back up into its input channel.
    initial
    begin
        int hold_mark;
        int holds_done;
        int stall;
        hold_mark  = 400;
        holds_done = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_done < 2 && results_done >= hold_mark)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
                hold_mark = hold_mark + 700;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 4)
                    repeat ($urandom_range(50, 150)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                stall = pick_gap();
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // Watchdog for a block that stops answering.
    initial
    begin
        #(25_000_000);
        $display("sorted_key_table_floor_search_top: mismatch");
        $finish;
    end

endmodule
